// File: src/gcpb_pkg.sv
// ============================================================================
// gcpb_pkg
// Shared types and constants for the grid cell point binner.
// ============================================================================
package gcpb_pkg;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_COUNT   = 2'd1,
        OP_SCATTER = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_INV_X    = 3'd3;
    localparam logic [2:0] REG_INV_Y    = 3'd4;
    localparam logic [2:0] REG_INV_Z    = 3'd5;
    localparam logic [2:0] REG_DIVS     = 3'd6;

    localparam int DIV_BITS  = 11;
    localparam int SLOT_BITS = 24;
    localparam int CNT_BITS  = 25;
    localparam int CELL_BITS = 10;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_LIN1,
        ST_LIN2,
        ST_WALK_RD,
        ST_WALK,
        ST_RD,
        ST_MOD,
        ST_OUT
    } state_t;

endpackage

// File: src/gcpb_axis_quant.sv
// ============================================================================
// gcpb_axis_quant
// Registered quantisation of one coordinate into a clamped cell index.
// ============================================================================
module gcpb_axis_quant #(
    parameter int COORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [31:0]            coord,
    input  logic signed [31:0]            origin,
    input  logic [31:0]                   inv,
    input  logic [gcpb_pkg::DIV_BITS-1:0] div,
    output logic [gcpb_pkg::DIV_BITS-1:0] index
);
    import gcpb_pkg::*;

    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS-1:0]      du;
    logic                       pos;
    logic [COORD_BITS+31:0]     prod_reg;
    logic                       pos_reg;
    logic [COORD_BITS+15:0]     q;

    // Difference of the sign-extended coordinate and origin.
    assign diff = {coord[COORD_BITS-1], coord[COORD_BITS-1:0]}
                - {origin[COORD_BITS-1], origin[COORD_BITS-1:0]};
    assign pos  = !diff[COORD_BITS] && (diff != '0);
    assign du   = diff[COORD_BITS-1:0];

    // One multiplication, registered before the clamp.
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= du * inv;
            pos_reg  <= pos;
        end
    end

    // Floor of the Q16.16 product: zero if not positive, else at most div - 1.
    always_comb begin
        q = prod_reg[COORD_BITS+31:16];
        if (!pos_reg) begin
            index = '0;
        end else if (q >= {{(COORD_BITS+16-DIV_BITS){1'b0}}, div}) begin
            index = div - 1'b1;
        end else begin
            index = q[DIV_BITS-1:0];
        end
    end
endmodule

// File: src/grid_cell_point_binner_top.sv
// ============================================================================
// grid_cell_point_binner_top
// Two-pass counting sort of 3-D points into a uniform grid of cells.
// ============================================================================
//  channel  | ports                            | handshake
//  input    | s_opcode, s_coord_*, s_cell_select | s_valid / s_ready
//  result   | m_status .. m_box_max_z          | m_valid / m_ready
//  config   | cfg_we, cfg_index, cfg_data      | write enable only
// A count or scatter request passes the multiply, two linear-index, read and
// modify states to the result register, a read only the read and modify ones;
// a clear writes one cell table row a cycle. The first scatter after a clear
// adds a prefix walk over the tally memory (one read port), a read and a write
// state per cell. After reset the block clears the cell table and passes its
// output state before its first request; a stalled result holds it there.
module grid_cell_point_binner_top #(
    parameter int MAX_CELLS  = 1024,
    parameter int MAX_POINTS = 16777216,
    parameter int COORD_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [32:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_opcode,
    input  logic signed [31:0]              s_coord_x,
    input  logic signed [31:0]              s_coord_y,
    input  logic signed [31:0]              s_coord_z,
    input  logic [gcpb_pkg::CELL_BITS-1:0]  s_cell_select,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic [gcpb_pkg::CELL_BITS-1:0]  m_cell_number,
    output logic [gcpb_pkg::SLOT_BITS-1:0]  m_dest_slot,
    output logic [gcpb_pkg::CNT_BITS-1:0]   m_point_count,
    output logic signed [31:0]              m_box_min_x,
    output logic signed [31:0]              m_box_min_y,
    output logic signed [31:0]              m_box_min_z,
    output logic signed [31:0]              m_box_max_x,
    output logic signed [31:0]              m_box_max_y,
    output logic signed [31:0]              m_box_max_z
);
    import gcpb_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam logic [CNT_BITS-1:0] PT_MAX = CNT_BITS'(MAX_POINTS);
    localparam logic [AW-1:0] LAST = AW'(MAX_CELLS - 1);

    // Row of the main cell table: tally, fill, start and box.
    typedef struct packed {
        logic [CNT_BITS-1:0]  tally;
        logic [CNT_BITS-1:0]  filled;
        logic [SLOT_BITS-1:0] start;
        logic signed [31:0]   lx, ly, lz, hx, hy, hz;
    } row_t;

    // Configuration registers.
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [31:0]        inv_x_reg, inv_y_reg, inv_z_reg;
    logic [32:0]        divs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0; org_y_reg <= '0; org_z_reg <= '0;
            inv_x_reg <= 32'd65536; inv_y_reg <= 32'd65536;
            inv_z_reg <= 32'd65536; divs_reg <= 33'd4196353;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X: org_x_reg <= cfg_data[31:0];
                REG_ORIGIN_Y: org_y_reg <= cfg_data[31:0];
                REG_ORIGIN_Z: org_z_reg <= cfg_data[31:0];
                REG_INV_X:    inv_x_reg <= cfg_data[31:0];
                REG_INV_Y:    inv_y_reg <= cfg_data[31:0];
                REG_INV_Z:    inv_z_reg <= cfg_data[31:0];
                REG_DIVS:     divs_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Division counts, zero acting as one.
    logic [DIV_BITS-1:0] dx, dy, dz;
    assign dx = (divs_reg[10:0] == '0)  ? 11'd1 : divs_reg[10:0];
    assign dy = (divs_reg[21:11] == '0) ? 11'd1 : divs_reg[21:11];
    assign dz = (divs_reg[32:22] == '0) ? 11'd1 : divs_reg[32:22];

    // Coordinates are taken as signed values of COORD_BITS bits.
    function automatic logic signed [31:0] coord_ext(input logic [31:0] v);
        return 32'($signed(v[COORD_BITS-1:0]));
    endfunction

    // Request capture.
    state_t state_reg, state_next;
    op_t    op_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [CELL_BITS-1:0] sel_reg;
    logic accept;
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg  <= OP_COUNT;
        end else if (accept) begin
            op_reg  <= op_t'(s_opcode);
            cx_reg  <= coord_ext(s_coord_x);
            cy_reg  <= coord_ext(s_coord_y);
            cz_reg  <= coord_ext(s_coord_z);
            sel_reg <= s_cell_select;
        end
    end

    // Per-axis quantisers, loaded in the cycle after acceptance.
    logic [DIV_BITS-1:0] ix, iy, iz;
    logic q_load;
    assign q_load = (state_reg == ST_MUL);

    gcpb_axis_quant #(.COORD_BITS(COORD_BITS)) u_qx (
        .aclk(aclk), .load(q_load), .coord(cx_reg), .origin(org_x_reg),
        .inv(inv_x_reg), .div(dx), .index(ix));
    gcpb_axis_quant #(.COORD_BITS(COORD_BITS)) u_qy (
        .aclk(aclk), .load(q_load), .coord(cy_reg), .origin(org_y_reg),
        .inv(inv_y_reg), .div(dy), .index(iy));
    gcpb_axis_quant #(.COORD_BITS(COORD_BITS)) u_qz (
        .aclk(aclk), .load(q_load), .coord(cz_reg), .origin(org_z_reg),
        .inv(inv_z_reg), .div(dz), .index(iz));

    // Linear index over two registered multiply steps.
    logic [21:0] yz_reg;
    logic [10:0] ix_reg;
    logic [32:0] lin_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LIN1) begin
            yz_reg <= 22'(iy) + dy * iz;
            ix_reg <= ix;
        end
        if (state_reg == ST_LIN2) begin
            lin_reg <= 33'(ix_reg) + dx * yz_reg;
        end
    end

    logic [AW-1:0] cell_lin;
    assign cell_lin = (lin_reg >= 33'(MAX_CELLS)) ? LAST : lin_reg[AW-1:0];

    // Cell table memory, one read and one write port.
    row_t mem [MAX_CELLS];
    row_t rd_row_reg, wr_row;
    logic [AW-1:0] rd_addr, wr_addr;
    logic rd_en, wr_en;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_row;
        if (rd_en) rd_row_reg <= mem[rd_addr];
    end

    // Control registers.
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [SLOT_BITS-1:0] run_reg, run_next;
    logic ready_off_reg, ready_off_next;
    logic [AW-1:0] cell_reg, cell_next;
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            run_reg       <= '0;
            ready_off_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            run_reg       <= run_next;
            ready_off_reg <= ready_off_next;
        end
    end
    always_ff @(posedge aclk) cell_reg <= cell_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (op_t'(s_opcode))
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_READ:  state_next = ST_RD;
                        default:  state_next = ST_MUL;
                    endcase
                end
            end
            ST_CLEAR:   if (ptr_reg == CW'(MAX_CELLS - 1)) state_next = ST_OUT;
            ST_MUL:     state_next = ST_LIN1;
            ST_LIN1:    state_next = ST_LIN2;
            ST_LIN2:    state_next = (op_reg == OP_SCATTER && !ready_off_reg)
                                     ? ST_WALK_RD : ST_RD;
            ST_WALK_RD: state_next = ST_WALK;
            ST_WALK:    state_next = (ptr_reg == CW'(MAX_CELLS - 1)) ? ST_RD
                                                                     : ST_WALK_RD;
            ST_RD:      state_next = ST_MOD;
            ST_MOD:     state_next = ST_OUT;
            ST_OUT:     if (m_ready || !out_valid_reg) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory accesses and walk bookkeeping.
    always_comb begin
        ptr_next       = ptr_reg;
        run_next       = run_reg;
        ready_off_next = ready_off_reg;
        cell_next      = cell_reg;
        rd_en = 1'b0; rd_addr = cell_reg;
        wr_en = 1'b0; wr_addr = cell_reg; wr_row = rd_row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ptr_next  = '0;
                run_next  = '0;
                cell_next = s_cell_select[AW-1:0];
            end
            ST_CLEAR: begin
                wr_en = 1'b1; wr_addr = ptr_reg[AW-1:0];
                wr_row = '0;
                ptr_next = ptr_reg + 1'b1;
                ready_off_next = 1'b0;
            end
            ST_LIN2: cell_next = '0;
            ST_WALK_RD: begin
                rd_en = 1'b1; rd_addr = ptr_reg[AW-1:0];
            end
            ST_WALK: begin
                wr_en = 1'b1; wr_addr = ptr_reg[AW-1:0];
                wr_row.start = run_reg;
                run_next = run_reg + rd_row_reg.tally[SLOT_BITS-1:0];
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == CW'(MAX_CELLS - 1)) ready_off_next = 1'b1;
            end
            ST_RD: begin
                if (op_reg != OP_READ) cell_next = cell_lin;
                rd_en = 1'b1;
                rd_addr = (op_reg == OP_READ) ? cell_reg : cell_lin;
            end
            ST_MOD: begin
                if (op_reg == OP_COUNT) begin
                    wr_en = 1'b1;
                    if (rd_row_reg.tally < PT_MAX) wr_row.tally = rd_row_reg.tally + 1'b1;
                end else if (op_reg == OP_SCATTER &&
                             rd_row_reg.filled < rd_row_reg.tally) begin
                    wr_en = 1'b1;
                    wr_row.filled = rd_row_reg.filled + 1'b1;
                    if (rd_row_reg.filled == '0 || cx_reg < rd_row_reg.lx) wr_row.lx = cx_reg;
                    if (rd_row_reg.filled == '0 || cy_reg < rd_row_reg.ly) wr_row.ly = cy_reg;
                    if (rd_row_reg.filled == '0 || cz_reg < rd_row_reg.lz) wr_row.lz = cz_reg;
                    if (rd_row_reg.filled == '0 || cx_reg > rd_row_reg.hx) wr_row.hx = cx_reg;
                    if (rd_row_reg.filled == '0 || cy_reg > rd_row_reg.hy) wr_row.hy = cy_reg;
                    if (rd_row_reg.filled == '0 || cz_reg > rd_row_reg.hz) wr_row.hz = cz_reg;
                end
            end
            default: ;
        endcase
    end

    // Result register, loaded in the modify cycle or at the end of a clear.
    logic sel_ok;
    assign sel_ok = (32'(sel_reg) < 32'(MAX_CELLS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_MOD ||
                     (state_reg == ST_CLEAR && ptr_reg == CW'(MAX_CELLS - 1))) begin
            out_valid_reg <= (state_reg == ST_MOD) || (op_reg == OP_CLEAR);
        end else if (m_valid && m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            m_status <= 1'b0; m_cell_number <= '0; m_dest_slot <= '0;
            m_point_count <= '0;
            m_box_min_x <= '0; m_box_min_y <= '0; m_box_min_z <= '0;
            m_box_max_x <= '0; m_box_max_y <= '0; m_box_max_z <= '0;
        end else if (state_reg == ST_MOD) begin
            m_status <= 1'b0; m_dest_slot <= '0;
            m_box_min_x <= '0; m_box_min_y <= '0; m_box_min_z <= '0;
            m_box_max_x <= '0; m_box_max_y <= '0; m_box_max_z <= '0;
            m_cell_number <= (op_reg == OP_READ) ? sel_reg : CELL_BITS'(cell_reg);
            m_point_count <= wr_row.tally;
            if (op_reg == OP_READ && !sel_ok) begin
                m_point_count <= '0;
            end else if (op_reg != OP_COUNT) begin
                if (op_reg == OP_READ) begin
                    m_dest_slot <= ready_off_reg ? rd_row_reg.start : '0;
                end else if (rd_row_reg.filled < rd_row_reg.tally) begin
                    m_dest_slot <= rd_row_reg.start + rd_row_reg.filled[SLOT_BITS-1:0];
                end else begin
                    m_status <= 1'b1;
                end
                if (wr_row.filled != '0) begin
                    m_box_min_x <= wr_row.lx; m_box_min_y <= wr_row.ly;
                    m_box_min_z <= wr_row.lz; m_box_max_x <= wr_row.hx;
                    m_box_max_y <= wr_row.hy; m_box_max_z <= wr_row.hz;
                end
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign s_ready = (state_reg == ST_IDLE);
endmodule
